>>> src/sks_pkg.sv
// Package for the smallest-k selector: cell operation codes and the
// control word that the top level broadcasts to the cell chain.
// No dependencies.
package sks_pkg;

    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 5;

    // Operation that every cell applies in a cycle
    typedef enum logic [1:0] {
        MODE_HOLD    = 2'd0,
        MODE_INSERT  = 2'd1,
        MODE_REPLACE = 2'd2,
        MODE_SHIFT   = 2'd3
    } t_mode;

    // Broadcast control word for the cell chain
    typedef struct packed {
        t_mode                       mode;
        logic signed [SAMPLE_W-1:0]  sample;
    } t_cell_ctl;

endpackage

>>> src/smallest_k_selector_unit.sv
// Top level of the smallest-k selector: control, output word register and
// the chain of sks_cell instances. Depends on sks_pkg and sks_cell.
//
// Usage:
//   Input words (i_sample, i_final_item) arrive on i_in_valid/o_in_ready.
//   Result words (o_kept_value, o_last_out, o_empty_set) leave on
//   o_out_valid/i_out_ready. i_cfg_we writes keep_count (reset value 16);
//   counts above MAX_KEEP act as MAX_KEEP.
//   While a set is loading, one sample is taken every cycle: each cell
//   compares it with its own value and the chain inserts it in sorted
//   order; once k are kept, it drops the largest of those values and
//   the sample. After the final word of a set the block passes through
//   a decide state, then shifts out the (kept - k) surplus large values,
//   then emits k words largest first, one per cycle while i_out_ready is
//   high. An empty answer is one word, loaded after the decide state.
//   Input is not taken while results of a set are pending; a stalled
//   receiver holds the output register and the chain in place.
//   Reset clears the kept count and control state; the next set can start
//   in the cycle after the last result word is loaded.
module smallest_k_selector_unit
    import sks_pkg::*;
#(
    parameter int MAX_KEEP = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_final_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_kept_value,
    output logic                       o_last_out,
    output logic                       o_empty_set,
    input  logic                       i_cfg_we,
    input  logic [COUNT_W-1:0]         i_cfg_keep_count
);

    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [4:0] {
        ST_LOAD   = 5'b00001,
        ST_DECIDE = 5'b00010,
        ST_SKIP   = 5'b00100,
        ST_EMIT   = 5'b01000,
        ST_EMPTY  = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic [CW-1:0]              r_left, n_left;
    logic [COUNT_W-1:0]         r_keep_count;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_kept_value;
    logic                       r_last_out;
    logic                       r_empty_set;

    logic                       in_accept;
    logic                       out_free;
    logic                       out_load;
    logic signed [SAMPLE_W-1:0] load_value;
    logic                       load_last;
    logic                       load_empty;
    logic [CW-1:0]              k_eff;
    logic [EW-1:0]              keep_ext;
    t_cell_ctl                  ctl;

    logic [MAX_KEEP-1:0]        w_above;
    logic signed [SAMPLE_W-1:0] w_val [MAX_KEEP];

    // clamp the configured count to the chain length
    assign keep_ext = EW'(r_keep_count);
    assign k_eff    = (keep_ext > EW'(MAX_KEEP)) ? CW'(MAX_KEEP) : CW'(keep_ext);

    assign o_in_ready = (r_state == ST_LOAD);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // sequence loading, surplus drop and emission
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_left     = r_left;
        ctl.mode   = MODE_HOLD;
        ctl.sample = i_sample;
        out_load   = 1'b0;
        load_value = w_val[0];
        load_last  = 1'b0;
        load_empty = 1'b0;
        case (r_state)
            ST_LOAD: begin
                if (in_accept) begin
                    if (r_cnt < k_eff) begin
                        ctl.mode = MODE_INSERT;
                        n_cnt    = r_cnt + CW'(1);
                    end else begin
                        ctl.mode = MODE_REPLACE;
                    end
                    if (i_final_item) begin
                        n_state = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (k_eff == '0 || r_cnt < k_eff) begin
                    n_state = ST_EMPTY;
                end else if (r_cnt > k_eff) begin
                    n_left  = r_cnt - k_eff;
                    n_state = ST_SKIP;
                end else begin
                    n_left  = k_eff;
                    n_state = ST_EMIT;
                end
            end
            ST_SKIP: begin
                ctl.mode = MODE_SHIFT;
                n_left   = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_left  = k_eff;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    ctl.mode  = MODE_SHIFT;
                    out_load  = 1'b1;
                    load_last = (r_left == CW'(1));
                    n_left    = r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        n_cnt   = '0;
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    load_value = '0;
                    load_last  = 1'b1;
                    load_empty = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_cnt        <= '0;
            r_left       <= '0;
            r_keep_count <= COUNT_W'(16);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            if (i_cfg_we) begin
                r_keep_count <= i_cfg_keep_count;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_kept_value <= load_value;
            r_last_out   <= load_last;
            r_empty_set  <= load_empty;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kept_value = r_kept_value;
    assign o_last_out   = r_last_out;
    assign o_empty_set  = r_empty_set;

    // sorted chain, largest value in cell 0
    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEEP; gi++) begin : g_cell
            logic                       left_above;
            logic signed [SAMPLE_W-1:0] left_val;
            logic                       right_above;
            logic signed [SAMPLE_W-1:0] right_val;
            if (gi == 0) begin : g_first
                assign left_above = 1'b1;
                assign left_val   = '0;
            end else begin : g_mid_l
                assign left_above = w_above[gi-1];
                assign left_val   = w_val[gi-1];
            end
            if (gi == MAX_KEEP - 1) begin : g_last
                assign right_above = 1'b0;
                assign right_val   = '0;
            end else begin : g_mid_r
                assign right_above = w_above[gi+1];
                assign right_val   = w_val[gi+1];
            end
            sks_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (ctl),
                .i_valid       (CW'(gi) < r_cnt),
                .i_left_above  (left_above),
                .i_left_val    (left_val),
                .i_right_above (right_above),
                .i_right_val   (right_val),
                .o_above       (w_above[gi]),
                .o_val         (w_val[gi])
            );
        end
    endgenerate

    // kept count never exceeds the chain
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_KEEP))
        else $error("kept count above chain length");

    // insert only while the chain has a free cell
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && ctl.mode == MODE_INSERT) |-> (r_cnt < CW'(MAX_KEEP)))
        else $error("insert into full chain");

    // last word of a set returns to loading with an empty chain
    a_set_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && load_last) |=> (r_cnt == '0 && r_state == ST_LOAD))
        else $error("chain not cleared after last word");

    // emitted values leave in descending order
    generate
        if (MAX_KEEP > 1) begin : g_order_chk
            a_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (r_state == ST_EMIT && r_left > CW'(1)) |-> (w_val[0] >= w_val[1]))
                else $error("chain out of order during emission");
        end
    endgenerate

endmodule

>>> src/sks_cell.sv
// One cell of the sorted chain: holds one kept value, largest in cell 0.
// Depends on sks_pkg.
module sks_cell
    import sks_pkg::*;
(
    input  logic                       i_clk,
    input  t_cell_ctl                  i_ctl,
    input  logic                       i_valid,
    input  logic                       i_left_above,
    input  logic signed [SAMPLE_W-1:0] i_left_val,
    input  logic                       i_right_above,
    input  logic signed [SAMPLE_W-1:0] i_right_val,
    output logic                       o_above,
    output logic signed [SAMPLE_W-1:0] o_val
);

    logic signed [SAMPLE_W-1:0] r_val;
    logic signed [SAMPLE_W-1:0] n_val;

    // flag a kept value that lies above the incoming sample
    assign o_above = i_valid && (r_val > i_ctl.sample);
    assign o_val   = r_val;

    // pick the next value from self, sample or a neighbor
    always_comb begin
        n_val = r_val;
        case (i_ctl.mode)
            MODE_INSERT: begin
                if (!o_above) begin
                    n_val = i_left_above ? i_ctl.sample : i_left_val;
                end
            end
            MODE_REPLACE: begin
                if (i_right_above) begin
                    n_val = i_right_val;
                end else if (o_above) begin
                    n_val = i_ctl.sample;
                end
            end
            MODE_SHIFT: begin
                n_val = i_right_val;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
